[hw/rtl/timer_slot_table_assert.svh]
// assertion macros for the timer slot table rtl
// no dependencies; included by modules that carry assertions
`ifndef TIMER_SLOT_TABLE_ASSERT_SVH
`define TIMER_SLOT_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

`define TST_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define TST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define TST_ASSERT(label, clk, rstn, prop, msg)

`define TST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

[hw/rtl/tst_pkg.sv]
// shared types and constants of the timer slot table
// no dependencies; imported by tst_engine, timer_slot_table, timer_slot_table_check and timer_slot_table_test
package tst_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ID_W       = 31;
    localparam int TIME_W     = 32;
    localparam logic [TIME_W-1:0] ID_LIMIT = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_REJECTED  = 3'd1,
        KIND_REMOVED   = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_FIRED     = 3'd4,
        KIND_TICK_DONE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic              wall;
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   period;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef struct packed {
        mode_t             mode;
        logic              clock_kind;
        logic [TIME_W-1:0] due_time;
        logic [ID_W-1:0]   period;
        logic [ID_W-1:0]   target_id;
        logic [TIME_W-1:0] mono_now;
        logic [TIME_W-1:0] wall_now;
        logic              wall_valid;
    } cmd_t;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] timer_id;
        logic            last;
    } result_t;

endpackage

[hw/rtl/tst_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tst_engine.sv]
// command sequencer: add, remove and tick scan over the slot ram
// depends on tst_pkg and timer_slot_table_assert.svh
`include "timer_slot_table_assert.svh"

module tst_engine import tst_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               ram_we,
    output logic [IDX_W-1:0]   ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata,
    output logic [IDX_W-1:0]   ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [SLOT_COUNT-1:0]   used_reg, used_next;
    logic [TIME_W-1:0]       next_ident_reg, next_ident_next;
    result_t                 res_reg, res_next;

    slot_entry_t       ent;
    slot_entry_t       wr_entry;
    logic [IDX_W-1:0]  free_idx;
    logic              free_found;
    logic              table_full;
    logic              ids_out;
    logic [TIME_W-1:0] newest;
    logic [TIME_W-1:0] period_ext;
    logic [TIME_W-1:0] mono_diff;
    logic [TIME_W-1:0] now_time;
    logic              live;
    logic              wall_arm;
    logic              fire;
    logic              arm;
    logic              match;
    logic              at_last;

    assign ent = slot_entry_t'(ram_rdata);

    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!used_reg[i] && !free_found) begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign table_full = &used_reg;
    assign ids_out    = (next_ident_reg == '0) || (next_ident_reg > ID_LIMIT);
    assign newest     = next_ident_reg - TIME_W'(1);
    assign period_ext = {1'b0, ent.period};
    assign mono_diff  = cmd_reg.mono_now - ent.due;
    assign now_time   = ent.wall ? cmd_reg.wall_now : cmd_reg.mono_now;
    assign live       = used_reg[idx_reg] && ({1'b0, ent.ident} <= newest);
    assign wall_arm   = (ent.due == '0) && (ent.period != '0);
    assign fire       = live && (ent.wall
                        ? (cmd_reg.wall_valid && !wall_arm && (cmd_reg.wall_now >= ent.due))
                        : !mono_diff[TIME_W-1]);
    assign arm        = live && ent.wall && cmd_reg.wall_valid && wall_arm;
    assign match      = used_reg[idx_reg] && (ent.ident == cmd_reg.target_id);
    assign at_last    = (idx_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            next_ident_reg <= TIME_W'(1);
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            next_ident_reg <= next_ident_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        next_ident_next = next_ident_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        wr_entry        = ent;
        ram_raddr       = idx_reg;
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next = cmd;
                    idx_next = '0;
                    unique case (cmd.mode)
                        MODE_ADD:    state_next = ST_ADD;
                        MODE_REMOVE: state_next = ST_SCAN_RD;
                        MODE_TICK:   state_next = ST_SCAN_RD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end

            ST_ADD: begin
                state_next = ST_EMIT;
                if (ids_out || table_full) begin
                    res_next = '{kind: KIND_REJECTED, timer_id: '0, last: 1'b1};
                end else begin
                    ram_we              = 1'b1;
                    ram_waddr           = free_idx;
                    wr_entry.ident      = next_ident_reg[ID_W-1:0];
                    wr_entry.wall       = cmd_reg.clock_kind;
                    wr_entry.due        = cmd_reg.due_time;
                    wr_entry.period     = cmd_reg.period;
                    used_next[free_idx] = 1'b1;
                    next_ident_next     = next_ident_reg + TIME_W'(1);
                    res_next = '{kind: KIND_ADDED, timer_id: next_ident_reg[ID_W-1:0],
                                 last: 1'b1};
                end
            end

            ST_SCAN_RD: begin
                ram_raddr  = idx_reg;
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK: begin
                if (cmd_reg.mode == MODE_REMOVE) begin
                    if (match) begin
                        used_next[idx_reg] = 1'b0;
                        res_next = '{kind: KIND_REMOVED, timer_id: cmd_reg.target_id,
                                     last: 1'b1};
                        state_next = ST_EMIT;
                    end else if (at_last) begin
                        res_next   = '{kind: KIND_NOT_FOUND, timer_id: '0, last: 1'b1};
                        state_next = ST_EMIT;
                    end else begin
                        idx_next  = idx_reg + IDX_W'(1);
                        ram_raddr = idx_reg + IDX_W'(1);
                    end
                end else begin
                    if (fire) begin
                        res_next   = '{kind: KIND_FIRED, timer_id: ent.ident, last: 1'b0};
                        state_next = ST_EMIT;
                        if (ent.period == '0) begin
                            used_next[idx_reg] = 1'b0;
                        end else begin
                            ram_we       = 1'b1;
                            wr_entry.due = now_time + period_ext;
                        end
                    end else begin
                        if (arm) begin
                            ram_we       = 1'b1;
                            wr_entry.due = cmd_reg.wall_now + period_ext;
                        end
                        if (at_last) begin
                            res_next   = '{kind: KIND_TICK_DONE, timer_id: '0, last: 1'b1};
                            state_next = ST_EMIT;
                        end else begin
                            idx_next  = idx_reg + IDX_W'(1);
                            ram_raddr = idx_reg + IDX_W'(1);
                        end
                    end
                end
            end

            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if (res_reg.last) begin
                        state_next = ST_IDLE;
                    end else if (at_last) begin
                        res_next = '{kind: KIND_TICK_DONE, timer_id: '0, last: 1'b1};
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign ram_wdata = wr_entry;
    assign res       = res_reg;

    `TST_ASSERT(a_ident_range, aclk, aresetn, (next_ident_reg - TIME_W'(1)) <= ID_LIMIT, "next id out of range")
    `TST_ASSERT_NEXT(a_add_takes_slot, aclk, aresetn, (state_reg == ST_ADD) && ram_we, $countones(used_reg) == $past($countones(used_reg)) + 1, "add did not take exactly one slot")
    `TST_ASSERT(a_fire_in_tick, aclk, aresetn, (state_reg == ST_EMIT) && (res_reg.kind == KIND_FIRED) |-> (cmd_reg.mode == MODE_TICK), "fired word outside a tick")
    `TST_ASSERT(a_remove_no_write, aclk, aresetn, !(ram_we && (state_reg == ST_SCAN_CHK) && (cmd_reg.mode == MODE_REMOVE)), "remove wrote the slot ram")

endmodule

[hw/rtl/timer_slot_table.sv]
// timer slot table top level: stream ports, input decode, output register
// depends on tst_pkg, tst_ram and tst_engine
//
//  channel | dir | group                                 | word
//  --------+-----+---------------------------------------+-------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser     | one command (add, remove, tick)
//  m_      | out | m_tvalid m_tready m_tdata m_tuser m_tlast | one result word
//
//  one command at a time; s_tready is high only while the sequencer is idle
//  add: one slot write, then the result; remove: up to SLOT_COUNT slot ram reads
//  tick: reads every slot through the one-read-port slot ram, plus a word per fired slot
//  reset: aresetn low clears all slots and sets the next id to one, no clearing pass
//  a stalled m_ side holds the result in the output register and the scan waits behind it
module timer_slot_table import tst_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // clock_kind[0], due_time[32:1], period[63:33], target_id[94:64],
    // mono_now[126:95], wall_now[158:127], wall_valid[159]
    input  logic [159:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // timer_id[30:0], zero[31]
    output logic [31:0]  m_tdata,
    // kind[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    cmd_t               cmd;
    result_t            res;
    logic               res_valid;
    logic               res_ready;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;

    always_comb begin
        cmd.mode       = mode_t'(s_tuser);
        cmd.clock_kind = s_tdata[0];
        cmd.due_time   = s_tdata[32:1];
        cmd.period     = s_tdata[63:33];
        cmd.target_id  = s_tdata[94:64];
        cmd.mono_now   = s_tdata[126:95];
        cmd.wall_now   = s_tdata[158:127];
        cmd.wall_valid = s_tdata[159];
    end

    tst_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.timer_id};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;

endmodule

[verif/timer_slot_table_check.sv]
// result checker for the timer slot table: tracks the slot table from the accepted
// command words and compares every result word with the predicted one
// depends on tst_pkg
module timer_slot_table_check import tst_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [159:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    output int           mismatches,
    output int           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic              slot_used   [SLOT_COUNT];
    logic [ID_W-1:0]   slot_ident  [SLOT_COUNT];
    logic              slot_wall   [SLOT_COUNT];
    logic [TIME_W-1:0] slot_due    [SLOT_COUNT];
    logic [ID_W-1:0]   slot_period [SLOT_COUNT];
    logic [TIME_W-1:0] next_id;

    result_t pending_results[$];
    result_t want;

    function automatic void queue_result(kind_t kind, logic [ID_W-1:0] id, logic lst);
        result_t r;
        r.kind     = kind;
        r.timer_id = id;
        r.last     = lst;
        pending_results.push_back(r);
    endfunction

    task automatic apply_command(input mode_t mode, input logic [159:0] word);
        logic              clock_kind;
        logic [TIME_W-1:0] due_time;
        logic [ID_W-1:0]   period;
        logic [ID_W-1:0]   target;
        logic [TIME_W-1:0] mono_now;
        logic [TIME_W-1:0] wall_now;
        logic              wall_ok;
        logic [TIME_W-1:0] newest;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] lag;
        logic              taken;
        logic              fire;
        clock_kind = word[0];
        due_time   = word[32:1];
        period     = word[63:33];
        target     = word[94:64];
        mono_now   = word[126:95];
        wall_now   = word[158:127];
        wall_ok    = word[159];
        taken      = 1'b0;
        case (mode)
            MODE_ADD: begin
                if (next_id == '0 || next_id > ID_LIMIT) begin
                    queue_result(KIND_REJECTED, '0, 1'b1);
                end else begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!taken && !slot_used[i]) begin
                            taken          = 1'b1;
                            slot_used[i]   = 1'b1;
                            slot_ident[i]  = next_id[ID_W-1:0];
                            slot_wall[i]   = clock_kind;
                            slot_due[i]    = due_time;
                            slot_period[i] = period;
                            queue_result(KIND_ADDED, next_id[ID_W-1:0], 1'b1);
                            next_id        = next_id + 1;
                        end
                    end
                    if (!taken) begin
                        queue_result(KIND_REJECTED, '0, 1'b1);
                    end
                end
            end
            MODE_REMOVE: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!taken && slot_used[i] && slot_ident[i] == target) begin
                        taken        = 1'b1;
                        slot_used[i] = 1'b0;
                        queue_result(KIND_REMOVED, target, 1'b1);
                    end
                end
                if (!taken) begin
                    queue_result(KIND_NOT_FOUND, '0, 1'b1);
                end
            end
            MODE_TICK: begin
                newest = next_id - 1;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    fire     = 1'b0;
                    now_time = '0;
                    if (slot_used[i] && {1'b0, slot_ident[i]} <= newest) begin
                        if (slot_wall[i]) begin
                            if (wall_ok) begin
                                if (slot_due[i] == '0 && slot_period[i] != '0) begin
                                    slot_due[i] = wall_now + slot_period[i];
                                end else if (wall_now >= slot_due[i]) begin
                                    fire     = 1'b1;
                                    now_time = wall_now;
                                end
                            end
                        end else begin
                            lag = mono_now - slot_due[i];
                            if (!lag[TIME_W-1]) begin
                                fire     = 1'b1;
                                now_time = mono_now;
                            end
                        end
                    end
                    if (fire) begin
                        queue_result(KIND_FIRED, slot_ident[i], 1'b0);
                        if (slot_period[i] == '0) begin
                            slot_used[i] = 1'b0;
                        end else begin
                            slot_due[i] = now_time + slot_period[i];
                        end
                    end
                end
                queue_result(KIND_TICK_DONE, '0, 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_used[i] = 1'b0;
            end
            next_id = 1;
            pending_results.delete();
            mismatches = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_command(mode_t'(s_tuser), s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing pending: kind %0d, timer_id %0d",
                           m_tuser, m_tdata[ID_W-1:0]);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[ID_W-1:0] !== want.timer_id) begin
                        $error("timer_id: expected %0d, actual %0d",
                               want.timer_id, m_tdata[ID_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[31] !== 1'b0) begin
                        $error("zero: expected 0, actual %0d", m_tdata[31]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

[verif/timer_slot_table_test.sv]
// testbench top for the timer slot table: clock, reset, command stimulus and verdict
// depends on tst_pkg, timer_slot_table and timer_slot_table_check
module timer_slot_table_test import tst_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 34;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    int mismatches;
    int outstanding;
    int send_idle = 26;
    int recv_idle = 88;
    int cycle_count = 0;

    timer_slot_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    timer_slot_table_check result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[timer_slot_table] ERROR");
            $finish;
        end
    end

    function automatic logic [159:0] pack_fields(logic ck, logic [31:0] due,
                                                 logic [30:0] per, logic [30:0] tgt,
                                                 logic [31:0] mono, logic [31:0] wall,
                                                 logic wv);
        return {wv, wall, mono, tgt, per, due, ck};
    endfunction

    task automatic send_cmd(input mode_t mode, input logic [159:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= word;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    initial begin
        logic [31:0] mono_clk;
        logic [31:0] wall_clk;
        logic [31:0] due;
        logic [30:0] per;
        logic        ck;
        int          adds_sent;
        int          items_done;
        int          pick;
        int          sel;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table
        send_cmd(MODE_TICK, pack_fields(1'($urandom), $urandom, 31'($urandom),
                                        31'($urandom), '0, '0, 1'b0));
        send_cmd(MODE_REMOVE, pack_fields(1'($urandom), $urandom, 31'($urandom), '0,
                                          $urandom, $urandom, 1'($urandom)));
        // fill every slot with extreme due times and intervals, then one more
        for (int i = 0; i < SLOT_COUNT; i++) begin
            case ((i >> 1) & 3)
                0: due = 32'd0;
                1: due = 32'hffff_ffff;
                2: due = 32'd100;
                default: due = 32'h8000_0000;
            endcase
            per = (i < 8) ? 31'd0 : (i & 4) ? 31'd50 : 31'h7fff_ffff;
            send_cmd(MODE_ADD, pack_fields(i[0], due, per, 31'($urandom), $urandom,
                                           $urandom, 1'($urandom)));
        end
        send_cmd(MODE_ADD, pack_fields(1'b0, $urandom, 31'($urandom), 31'($urandom),
                                       $urandom, $urandom, 1'($urandom)));
        send_cmd(MODE_TICK, pack_fields(1'($urandom), $urandom, 31'($urandom),
                                        31'($urandom), 32'hffff_ffff, 32'd0, 1'b0));
        send_cmd(MODE_TICK, pack_fields(1'($urandom), $urandom, 31'($urandom),
                                        31'($urandom), 32'd0, 32'hffff_ffff, 1'b1));
        send_cmd(MODE_TICK, pack_fields(1'($urandom), $urandom, 31'($urandom),
                                        31'($urandom), 32'h7fff_ffff, 32'd5, 1'b1));
        send_cmd(MODE_REMOVE, pack_fields(1'($urandom), $urandom, 31'($urandom),
                                          31'h7fff_ffff, $urandom, $urandom,
                                          1'($urandom)));
        send_cmd(MODE_REMOVE, pack_fields(1'($urandom), $urandom, 31'($urandom), 31'd10,
                                          $urandom, $urandom, 1'($urandom)));
        send_cmd(MODE_NOP, pack_fields(1'($urandom), $urandom, 31'($urandom),
                                       31'($urandom), $urandom, $urandom, 1'($urandom)));

        adds_sent = SLOT_COUNT + 1;
        mono_clk  = $urandom;
        wall_clk  = $urandom;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle  = (phase == 0) ? 26 : (phase == 1) ? 88 : 0;
            recv_idle  = (phase == 0) ? 88 : (phase == 1) ? 26 : 0;
            items_done = 0;
            while (items_done < RANDOM_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    ck  = 1'($urandom_range(1));
                    sel = $urandom_range(9);
                    per = (sel < 5) ? 31'd0 : (sel < 9) ? 31'($urandom_range(1, 400))
                                                        : 31'h7fff_ffff;
                    if (ck) begin
                        due = ($urandom_range(3) == 0) ? 32'd0
                                                       : wall_clk + $urandom_range(12) - 2;
                    end else begin
                        due = mono_clk + $urandom_range(600) - 100;
                    end
                    send_cmd(MODE_ADD, pack_fields(ck, due, per, 31'($urandom), $urandom,
                                                   $urandom, 1'($urandom)));
                    adds_sent++;
                    items_done++;
                end else if (pick < 58) begin
                    send_cmd(MODE_REMOVE, pack_fields(1'($urandom), $urandom,
                                                      31'($urandom),
                                                      31'($urandom_range(1, adds_sent + 1)),
                                                      $urandom, $urandom, 1'($urandom)));
                    items_done++;
                end else if (pick < 93) begin
                    mono_clk = mono_clk + $urandom_range(250);
                    wall_clk = wall_clk + $urandom_range(4);
                    send_cmd(MODE_TICK, pack_fields(1'($urandom), $urandom, 31'($urandom),
                                                    31'($urandom), mono_clk, wall_clk,
                                                    $urandom_range(3) != 0));
                    items_done++;
                end else if (pick < 97) begin
                    send_cmd(mode_t'($urandom_range(2)),
                             pack_fields(1'($urandom), $urandom, 31'($urandom),
                                         31'($urandom), $urandom, $urandom,
                                         1'($urandom)));
                    items_done++;
                end else begin
                    send_cmd(MODE_NOP, pack_fields(1'($urandom), $urandom, 31'($urandom),
                                                   31'($urandom), $urandom, $urandom,
                                                   1'($urandom)));
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[timer_slot_table] OK");
        end else begin
            $display("[timer_slot_table] ERROR");
        end
        $finish;
    end

endmodule
